// File: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transaction engine package
// Shared types, sequencer phase codes and register indexes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // configuration register indexes
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_SAMPLES = 1'b1;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd5;
    localparam logic [7:0] ACK_SAMPLES_RESET = 8'd8;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
    localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_HI  = 5'd1,
        PH_START_LO  = 5'd2,
        PH_BIT_SET   = 5'd3,
        PH_BIT_HIGH  = 5'd4,
        PH_BIT_HOLD  = 5'd5,
        PH_ACK_PRE   = 5'd6,
        PH_ACK_SMP   = 5'd7,
        PH_ACK_HIGH  = 5'd8,
        PH_ACK_LOW   = 5'd9,
        PH_RX_LOW    = 5'd10,
        PH_RX_HIGH   = 5'd11,
        PH_MACK_LOW  = 5'd12,
        PH_MACK_HIGH = 5'd13,
        PH_STOP_A    = 5'd14,
        PH_STOP_B    = 5'd15,
        PH_STOP_C    = 5'd16
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] address_byte;
        logic       read_mode;
        logic [7:0] byte_count;
        logic       sda_in;
        logic [7:0] tx_data;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       tx_taken;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic [1:0] status;
    } out_item_t;

endpackage

// File: hdl/i2cm_core.sv
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Holds the bus phase state and advances it by one step per accepted item.
// ----------------------------------------------------------------------------
module i2cm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  i2cm_pkg::in_item_t  item,
    input  logic [7:0]          phase_ticks,
    input  logic [7:0]          ack_samples,
    output i2cm_pkg::out_item_t result
);
    import i2cm_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_data_reg, shift_data_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] sample_count_reg, sample_count_next;
    logic       ack_seen_reg, ack_seen_next;
    logic       is_read_reg, is_read_next;
    logic [1:0] result_code_reg, result_code_next;
    logic       addr_stage_reg, addr_stage_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_count_reg   <= '0;
            bit_index_reg    <= '0;
            shift_data_reg   <= '0;
            bytes_left_reg   <= '0;
            sample_count_reg <= '0;
            ack_seen_reg     <= 1'b0;
            is_read_reg      <= 1'b0;
            result_code_reg  <= STATUS_OK;
            addr_stage_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            bit_index_reg    <= bit_index_next;
            shift_data_reg   <= shift_data_next;
            bytes_left_reg   <= bytes_left_next;
            sample_count_reg <= sample_count_next;
            ack_seen_reg     <= ack_seen_next;
            is_read_reg      <= is_read_next;
            result_code_reg  <= result_code_next;
            addr_stage_reg   <= addr_stage_next;
        end
    end

    always_comb
    begin
        logic [7:0] tick_inc;
        logic [7:0] sample_inc;
        logic [7:0] left_dec;
        logic       cur_bit;
        logic       last_byte;

        tick_inc   = tick_count_reg + 8'd1;
        sample_inc = sample_count_reg + 8'd1;

        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        bit_index_next    = bit_index_reg;
        shift_data_next   = shift_data_reg;
        bytes_left_next   = bytes_left_reg;
        sample_count_next = sample_count_reg;
        ack_seen_next     = ack_seen_reg;
        is_read_next      = is_read_reg;
        result_code_next  = result_code_reg;
        addr_stage_next   = addr_stage_reg;

        result          = '0;
        result.rx_data  = 8'd0;
        left_dec        = bytes_left_reg;

        if (phase_reg == PH_IDLE)
        begin
            if (item.command)
            begin
                is_read_next      = item.read_mode;
                bytes_left_next   = item.byte_count;
                shift_data_next   = {item.address_byte[7:1], item.read_mode};
                bit_index_next    = 3'd0;
                result_code_next  = STATUS_OK;
                addr_stage_next   = 1'b1;
                ack_seen_next     = 1'b0;
                sample_count_next = 8'd0;
                phase_next        = PH_START_HI;
                tick_count_next   = 8'd0;
            end
        end
        else if (phase_reg == PH_ACK_SMP)
        begin
            if (!item.sda_in)
            begin
                ack_seen_next   = 1'b1;
                phase_next      = PH_ACK_HIGH;
                tick_count_next = 8'd0;
            end
            else
            begin
                sample_count_next = sample_inc;
                if (sample_inc >= ack_samples)
                begin
                    ack_seen_next   = 1'b0;
                    phase_next      = PH_ACK_HIGH;
                    tick_count_next = 8'd0;
                end
            end
        end
        else
        begin
            tick_count_next = tick_inc;
            if (tick_inc >= phase_ticks)
            begin
                tick_count_next = 8'd0;
                unique case (phase_reg)
                    PH_START_HI: phase_next = PH_START_LO;
                    PH_START_LO:
                    begin
                        bit_index_next = 3'd0;
                        phase_next     = PH_BIT_SET;
                    end
                    PH_BIT_SET:  phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH: phase_next = PH_BIT_HOLD;
                    PH_BIT_HOLD:
                    begin
                        if (bit_index_reg == 3'd7)
                            phase_next = PH_ACK_PRE;
                        else
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_BIT_SET;
                        end
                    end
                    PH_ACK_PRE:
                    begin
                        sample_count_next = 8'd0;
                        ack_seen_next     = 1'b0;
                        phase_next        = PH_ACK_SMP;
                    end
                    PH_ACK_HIGH: phase_next = PH_ACK_LOW;
                    PH_ACK_LOW:
                    begin
                        if (!ack_seen_reg)
                        begin
                            result_code_next = addr_stage_reg ? STATUS_ADDR_NACK
                                                              : STATUS_DATA_NACK;
                            phase_next = PH_STOP_A;
                        end
                        else
                        begin
                            // the address acknowledge does not consume a data byte
                            if (addr_stage_reg)
                                addr_stage_next = 1'b0;
                            else if (bytes_left_reg != 8'd0)
                                left_dec = bytes_left_reg - 8'd1;
                            bytes_left_next = left_dec;
                            if (left_dec == 8'd0)
                                phase_next = PH_STOP_A;
                            else if (is_read_reg)
                            begin
                                bit_index_next  = 3'd0;
                                shift_data_next = 8'd0;
                                phase_next      = PH_RX_LOW;
                            end
                            else
                            begin
                                shift_data_next = item.tx_data;
                                result.tx_taken = 1'b1;
                                bit_index_next  = 3'd0;
                                phase_next      = PH_BIT_SET;
                            end
                        end
                    end
                    PH_RX_LOW: phase_next = PH_RX_HIGH;
                    PH_RX_HIGH:
                    begin
                        shift_data_next = {shift_data_reg[6:0], item.sda_in};
                        if (bit_index_reg == 3'd7)
                        begin
                            result.rx_valid = 1'b1;
                            result.rx_data  = shift_data_next;
                            phase_next      = PH_MACK_LOW;
                        end
                        else
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_RX_LOW;
                        end
                    end
                    PH_MACK_LOW: phase_next = PH_MACK_HIGH;
                    PH_MACK_HIGH:
                    begin
                        if (bytes_left_reg != 8'd0)
                            left_dec = bytes_left_reg - 8'd1;
                        bytes_left_next = left_dec;
                        if (left_dec != 8'd0)
                        begin
                            bit_index_next  = 3'd0;
                            shift_data_next = 8'd0;
                            phase_next      = PH_RX_LOW;
                        end
                        else
                            phase_next = PH_STOP_A;
                    end
                    PH_STOP_A: phase_next = PH_STOP_B;
                    PH_STOP_B: phase_next = PH_STOP_C;
                    PH_STOP_C:
                    begin
                        result.done_res = 1'b1;
                        result.status   = result_code_reg;
                        phase_next      = PH_IDLE;
                    end
                    default:
                    begin
                        // unknown phase code: drop back to the reset state
                        phase_next        = PH_IDLE;
                        bit_index_next    = 3'd0;
                        shift_data_next   = 8'd0;
                        bytes_left_next   = 8'd0;
                        sample_count_next = 8'd0;
                        ack_seen_next     = 1'b0;
                        is_read_next      = 1'b0;
                        result_code_next  = STATUS_OK;
                        addr_stage_next   = 1'b0;
                    end
                endcase
            end
        end

        // line drive follows the phase entered on this step
        cur_bit   = shift_data_next[~bit_index_next];
        last_byte = (bytes_left_next == 8'd1);
        result.scl_out = 1'b1;
        result.sda_out = 1'b1;
        unique case (phase_next)
            PH_START_LO: result.sda_out = 1'b0;
            PH_BIT_SET, PH_BIT_HOLD:
            begin
                result.scl_out = 1'b0;
                result.sda_out = cur_bit;
            end
            PH_BIT_HIGH: result.sda_out = cur_bit;
            PH_ACK_PRE, PH_ACK_LOW, PH_RX_LOW: result.scl_out = 1'b0;
            PH_MACK_LOW:
            begin
                result.scl_out = 1'b0;
                result.sda_out = last_byte;
            end
            PH_MACK_HIGH: result.sda_out = last_byte;
            PH_STOP_A:
            begin
                result.scl_out = 1'b0;
                result.sda_out = 1'b0;
            end
            PH_STOP_B: result.sda_out = 1'b0;
            default: ;
        endcase
        result.busy_res = (phase_next != PH_IDLE);
    end

endmodule

// File: hdl/i2c_master_transaction_engine.sv
// ----------------------------------------------------------------------------
// I2C master transaction engine
// Runs one whole I2C transaction (start, address, data, stop) per begin.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one item per transfer: a begin command or a
//   time tick with the sampled SDA level and the next write byte.
//   out_valid/out_ready return exactly one result per item: the SCL/SDA
//   drive, busy, tx_taken, a received byte and the done status.
//   An item is registered on acceptance and its result is registered when
//   the output register is empty or being read, and out_valid rises with it.
//   One item is accepted every cycle while the output drains;
//   the bus sequencer step is the combinational path between the two
//   registers.
//   When the receiver stalls, the result register holds and the input
//   register absorbs one more item, then in_ready drops.
//   Reset clears both pipeline valid flags, returns the sequencer to idle
//   with both lines released and loads phase_ticks 5, ack_samples 8.
//   cfg_we writes one register at cfg_index; write only while idle.
// ----------------------------------------------------------------------------
module i2c_master_transaction_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cm_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata
);
    import i2cm_pkg::*;

    logic [7:0] phase_ticks_val_reg;
    logic [7:0] ack_samples_val_reg;
    logic [7:0] phase_ticks_eff;
    logic [7:0] ack_samples_eff;

    logic       s1_valid_reg;
    in_item_t   s1_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  step_result;
    logic       advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_val_reg <= PHASE_TICKS_RESET;
            ack_samples_val_reg <= ACK_SAMPLES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PHASE_TICKS: phase_ticks_val_reg <= cfg_wdata;
                CFG_ACK_SAMPLES: ack_samples_val_reg <= cfg_wdata;
            endcase
        end
    end

    // a zero setting behaves as one
    assign phase_ticks_eff = (phase_ticks_val_reg == 8'd0) ? 8'd1 : phase_ticks_val_reg;
    assign ack_samples_eff = (ack_samples_val_reg == 8'd0) ? 8'd1 : ack_samples_val_reg;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_item_reg <= in_data;
        if (advance)
            out_item_reg <= step_result;
    end

    i2cm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .item        (s1_item_reg),
        .phase_ticks (phase_ticks_eff),
        .ack_samples (ack_samples_eff),
        .result      (step_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// File: bench/tb_i2c_master_transaction_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master transaction engine testbench
// Drives begin commands and timing ticks into the engine and checks every
// bus step against an item-by-item model of the sequencer: line drive, busy,
// write byte latch, received bytes and the stop status. Covers directed
// address/data NACK cases, reads and writes, zero and maximum register
// values, random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_engine;

    import i2cm_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 250;
    localparam int MAX_TICK_ITEMS = 300;
    localparam int NO_NACK        = -1;

    // ------------------------------------------------------------------------
    // Bus step predictor and scoreboard
    // ------------------------------------------------------------------------
    class bus_step_predictor;
        bit [7:0]  phase_ticks;
        bit [7:0]  ack_samples;
        phase_t    ph;
        bit [7:0]  tick_cnt;
        bit [2:0]  bit_idx;
        bit [7:0]  shreg;
        bit [7:0]  left;
        bit [7:0]  samples;
        bit        ack_ok;
        bit        rd_mode;
        bit        addr_phase;
        bit [1:0]  code;
        out_item_t expected_steps[$];
        int        errors;

        function new();
            phase_ticks = PHASE_TICKS_RESET;
            ack_samples = ACK_SAMPLES_RESET;
            ph          = PH_IDLE;
            tick_cnt    = '0;
            bit_idx     = '0;
            shreg       = '0;
            left        = '0;
            samples     = '0;
            ack_ok      = 1'b0;
            rd_mode     = 1'b0;
            addr_phase  = 1'b0;
            code        = STATUS_OK;
            errors      = 0;
        endfunction

        function void go(phase_t p);
            ph       = p;
            tick_cnt = '0;
        endfunction

        function out_item_t advance(in_item_t it);
            out_item_t r;
            bit [7:0]  tick_lim;
            bit [7:0]  smp_lim;
            r        = '0;
            tick_lim = (phase_ticks == 0) ? 8'd1 : phase_ticks;
            smp_lim  = (ack_samples == 0) ? 8'd1 : ack_samples;
            if (ph == PH_IDLE)
            begin
                if (it.command)
                begin
                    rd_mode    = it.read_mode;
                    left       = it.byte_count;
                    shreg      = it.read_mode ? (it.address_byte | 8'h01)
                                              : (it.address_byte & 8'hFE);
                    bit_idx    = '0;
                    code       = STATUS_OK;
                    addr_phase = 1'b1;
                    ack_ok     = 1'b0;
                    samples    = '0;
                    go(PH_START_HI);
                end
            end
            else if (ph == PH_ACK_SMP)
            begin
                // first low sample ends the slot, else give up after the limit
                if (!it.sda_in)
                begin
                    ack_ok = 1'b1;
                    go(PH_ACK_HIGH);
                end
                else
                begin
                    samples++;
                    if (samples >= smp_lim)
                    begin
                        ack_ok = 1'b0;
                        go(PH_ACK_HIGH);
                    end
                end
            end
            else
            begin
                tick_cnt++;
                if (tick_cnt >= tick_lim)
                begin
                    tick_cnt = '0;
                    case (ph)
                        PH_START_HI: go(PH_START_LO);
                        PH_START_LO:
                        begin
                            bit_idx = '0;
                            go(PH_BIT_SET);
                        end
                        PH_BIT_SET:  go(PH_BIT_HIGH);
                        PH_BIT_HIGH: go(PH_BIT_HOLD);
                        PH_BIT_HOLD:
                        begin
                            if (bit_idx == 3'd7)
                                go(PH_ACK_PRE);
                            else
                            begin
                                bit_idx++;
                                go(PH_BIT_SET);
                            end
                        end
                        PH_ACK_PRE:
                        begin
                            samples = '0;
                            ack_ok  = 1'b0;
                            go(PH_ACK_SMP);
                        end
                        PH_ACK_HIGH: go(PH_ACK_LOW);
                        PH_ACK_LOW:
                        begin
                            if (!ack_ok)
                            begin
                                code = addr_phase ? STATUS_ADDR_NACK : STATUS_DATA_NACK;
                                go(PH_STOP_A);
                            end
                            else
                            begin
                                if (addr_phase)
                                    addr_phase = 1'b0;
                                else if (left != 0)
                                    left--;
                                if (left == 0)
                                    go(PH_STOP_A);
                                else if (rd_mode)
                                begin
                                    bit_idx = '0;
                                    shreg   = '0;
                                    go(PH_RX_LOW);
                                end
                                else
                                begin
                                    shreg      = it.tx_data;
                                    r.tx_taken = 1'b1;
                                    bit_idx    = '0;
                                    go(PH_BIT_SET);
                                end
                            end
                        end
                        PH_RX_LOW: go(PH_RX_HIGH);
                        PH_RX_HIGH:
                        begin
                            shreg = {shreg[6:0], it.sda_in};
                            if (bit_idx == 3'd7)
                            begin
                                r.rx_valid = 1'b1;
                                r.rx_data  = shreg;
                                go(PH_MACK_LOW);
                            end
                            else
                            begin
                                bit_idx++;
                                go(PH_RX_LOW);
                            end
                        end
                        PH_MACK_LOW: go(PH_MACK_HIGH);
                        PH_MACK_HIGH:
                        begin
                            if (left != 0)
                                left--;
                            if (left != 0)
                            begin
                                bit_idx = '0;
                                shreg   = '0;
                                go(PH_RX_LOW);
                            end
                            else
                                go(PH_STOP_A);
                        end
                        PH_STOP_A: go(PH_STOP_B);
                        PH_STOP_B: go(PH_STOP_C);
                        PH_STOP_C:
                        begin
                            r.done_res = 1'b1;
                            r.status   = code;
                            go(PH_IDLE);
                        end
                        default: go(PH_IDLE);
                    endcase
                end
            end

            // line drive for the phase just entered
            r.scl_out = 1'b1;
            r.sda_out = 1'b1;
            case (ph)
                PH_START_LO: r.sda_out = 1'b0;
                PH_BIT_SET, PH_BIT_HOLD:
                begin
                    r.scl_out = 1'b0;
                    r.sda_out = shreg[3'd7 - bit_idx];
                end
                PH_BIT_HIGH: r.sda_out = shreg[3'd7 - bit_idx];
                PH_ACK_PRE, PH_ACK_LOW, PH_RX_LOW: r.scl_out = 1'b0;
                PH_MACK_LOW:
                begin
                    r.scl_out = 1'b0;
                    r.sda_out = (left == 1);
                end
                PH_MACK_HIGH: r.sda_out = (left == 1);
                PH_STOP_A:
                begin
                    r.scl_out = 1'b0;
                    r.sda_out = 1'b0;
                end
                PH_STOP_B: r.sda_out = 1'b0;
                default: ;
            endcase
            r.busy_res = (ph != PH_IDLE);
            return r;
        endfunction

        function void take_item(in_item_t it);
            expected_steps.push_back(advance(it));
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_step(out_item_t got);
            out_item_t want;
            if (expected_steps.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_steps.pop_front();
            cmp_field("scl_out",  want.scl_out,  got.scl_out);
            cmp_field("sda_out",  want.sda_out,  got.sda_out);
            cmp_field("busy_res", want.busy_res, got.busy_res);
            cmp_field("tx_taken", want.tx_taken, got.tx_taken);
            cmp_field("rx_valid", want.rx_valid, got.rx_valid);
            cmp_field("rx_data",  want.rx_data,  got.rx_data);
            cmp_field("done_res", want.done_res, got.done_res);
            cmp_field("status",   want.status,   got.status);
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_we;
    logic      cfg_index;
    logic [7:0] cfg_wdata;

    bus_step_predictor bus_pred;
    int  send_idle_pct;
    int  stall_pct;
    logic hold;
    int  quiet_cycles;

    i2c_master_transaction_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // result side: check on acceptance, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            bus_pred.check_step(out_data);
        if (hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // count cycles with work outstanding but no transaction moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            !(in_valid || bus_pred.pending() != 0))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("i2c_master_transaction_engine regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    task automatic send(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bus_pred.take_item(it);
    endtask

    function automatic in_item_t noise_tick(input int begin_pct);
        in_item_t it;
        it.command      = ($urandom_range(99) < begin_pct);
        it.address_byte = 8'($urandom);
        it.read_mode    = 1'($urandom_range(1));
        it.byte_count   = 8'($urandom);
        it.sda_in       = 1'($urandom_range(1));
        it.tx_data      = 8'($urandom);
        return it;
    endfunction

    // One begin, then ticks until the stop completes. The ack slot numbered
    // nack_slot (0 = address) is held high; other slots go high at noise_pct.
    task automatic run_txn(input bit rd, input logic [7:0] addr, input logic [7:0] cnt,
                           input int nack_slot, input int noise_pct, input int begin_pct,
                           inout int items);
        in_item_t it;
        int       slot;
        it              = noise_tick(0);
        it.command      = 1'b1;
        it.read_mode    = rd;
        it.address_byte = addr;
        it.byte_count   = cnt;
        send(it);
        items++;
        while (bus_pred.ph != PH_IDLE)
        begin
            it = noise_tick(begin_pct);
            if (bus_pred.ph == PH_ACK_SMP)
            begin
                slot = bus_pred.addr_phase ? 0 : 1 + int'(cnt) - int'(bus_pred.left);
                it.sda_in = (slot == nack_slot) ? 1'b1 : ($urandom_range(99) < noise_pct);
            end
            send(it);
            items++;
        end
    endtask

    task automatic random_phase(input int target);
        int         items;
        int         pick;
        int         nack;
        bit         rd;
        logic [7:0] cnt;
        items = 0;
        while (items < target)
        begin
            if ($urandom_range(99) < 10)
                send(noise_tick(0));
            rd   = 1'($urandom_range(1));
            pick = $urandom_range(99);
            // long counts stop early on a NACK so they stay short
            if (pick < 5)
            begin
                cnt  = 8'($urandom_range(255, 4));
                nack = rd ? 0 : $urandom_range(2, 0);
            end
            else
            begin
                cnt  = 8'($urandom_range(3, 0));
                nack = (pick < 15) ? 0 : (pick < 25) ? $urandom_range(3, 1) : NO_NACK;
            end
            run_txn(rd, 8'($urandom), cnt, nack, 15, 3, items);
        end
    endtask

    // drain, then write both registers back to back
    task automatic set_regs(input logic [7:0] ticks, input logic [7:0] samples);
        in_valid <= 1'b0;
        while (bus_pred.pending() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_index <= CFG_ACK_SAMPLES;
        cfg_wdata <= samples;
        @(posedge clk);
        cfg_we <= 1'b0;
        bus_pred.phase_ticks = ticks;
        bus_pred.ack_samples = samples;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int       n;
        in_item_t it;
        bus_pred      = new();
        n             = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_PHASE_TICKS;
        cfg_wdata     = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset timing, address bit 0 forced low on a write
        run_txn(1'b0, 8'hFF, 8'd0, NO_NACK, 0, 0, n);
        set_regs(8'd1, 8'd2);
        send(noise_tick(0));
        run_txn(1'b1, 8'h00, 8'd1, NO_NACK, 0, 0, n);
        run_txn(1'b1, 8'h5A, 8'd3, NO_NACK, 0, 0, n);
        run_txn(1'b0, 8'hA5, 8'd2, NO_NACK, 50, 0, n);
        run_txn(1'b0, 8'h3C, 8'd2, 1, 0, 0, n);
        run_txn(1'b0, 8'hC3, 8'd255, 2, 0, 0, n);
        run_txn(1'b1, 8'hFF, 8'd255, 0, 0, 0, n);
        run_txn(1'b0, 8'h81, 8'd1, NO_NACK, 0, 100, n);

        // zero registers behave as one
        set_regs(8'd0, 8'd0);
        random_phase(PHASE_ITEMS);

        set_regs(8'd2, 8'd3);
        send_idle_pct = 62;
        random_phase(PHASE_ITEMS);

        // hold the output off while the sender keeps offering
        set_regs(8'd1, 8'd255);
        send_idle_pct = 0;
        stall_pct     = 62;
        fork
            begin
                hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold <= 1'b0;
            end
        join_none
        random_phase(PHASE_ITEMS);

        // longest phase: cross one phase boundary, then finish at speed
        set_regs(8'd255, 8'd255);
        send_idle_pct = 13;
        stall_pct     = 13;
        it         = noise_tick(0);
        it.command = 1'b1;
        send(it);
        repeat (MAX_TICK_ITEMS) send(noise_tick(0));
        set_regs(8'd1, 8'd255);
        while (bus_pred.ph != PH_IDLE)
            send(noise_tick(0));

        set_regs(8'd3, 8'd5);
        random_phase(PHASE_ITEMS);

        in_valid <= 1'b0;
        while (bus_pred.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bus_pred.errors == 0)
            $display("i2c_master_transaction_engine regression: pass");
        else
            $display("i2c_master_transaction_engine regression: fail");
        $finish;
    end

endmodule

// File: i2c_master_transaction_engine.f
hdl/i2cm_pkg.sv
hdl/i2cm_core.sv
hdl/i2c_master_transaction_engine.sv
bench/tb_i2c_master_transaction_engine.sv
